/* hdl/integer_set_table_top_assert.svh */
// assertion macros shared by the integer set table modules
// expects signals named clock and reset in the including module
`ifndef INTEGER_SET_TABLE_TOP_ASSERT_SVH
`define INTEGER_SET_TABLE_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define IST_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ist: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define IST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ist: next-cycle check failed");

`endif

/* hdl/ist_pkg.sv */
// shared types for the integer set table: operation and status codes,
// controller states, command and status bundles, table size; no dependencies
package ist_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [2:0] {
      FUNC_INSERT  = 3'd0,
      FUNC_DELETE  = 3'd1,
      FUNC_SEARCH  = 3'd2,
      FUNC_REPLACE = 3'd3,
      FUNC_CLEAR   = 3'd4,
      FUNC_READ    = 3'd5
   } func_type;

   // result status codes carried in rsp_tuser
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_DUP       = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_RANGE     = 3'd4
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SCAN_END,
      ST_MOVE_RD,
      ST_READ,
      ST_EXEC
   } ctl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;     // capture request, restart scan
      logic scan;     // read next table entry for compare
      logic rd_last;  // read last valid entry (delete fill)
      logic rd_idx;   // read entry at request index
      logic exec;     // apply update and launch result
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      func_type func;
      logic     count_zero;
      logic     scan_last;
      logic     out_free;
   } sts_type;

   // table size, tied to the 5-bit count field of the response
   localparam int unsigned CAPACITY   = 16;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned FUNC_W     = 3;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned COUNT_W    = 5;

endpackage

/* hdl/ist_ctrl.sv */
// controller state machine for the integer set table
// depends on ist_pkg and integer_set_table_top_assert.svh
`include "integer_set_table_top_assert.svh"

module ist_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output ist_pkg::cmd_type   cmd,
   input  ist_pkg::sts_type   sts
);

   ist_pkg::ctl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ist_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ist_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ist_pkg::ST_DISPATCH;
            end
         end
         ist_pkg::ST_DISPATCH: begin
            case (sts.func)
               ist_pkg::FUNC_INSERT, ist_pkg::FUNC_DELETE,
               ist_pkg::FUNC_SEARCH, ist_pkg::FUNC_REPLACE: begin
                  state_in = sts.count_zero ? ist_pkg::ST_EXEC : ist_pkg::ST_SCAN;
               end
               ist_pkg::FUNC_READ: begin
                  state_in = ist_pkg::ST_READ;
               end
               default: begin
                  state_in = ist_pkg::ST_EXEC;
               end
            endcase
         end
         ist_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ist_pkg::ST_SCAN_END;
            end
         end
         ist_pkg::ST_SCAN_END: begin
            // last compare lands this cycle
            state_in = (sts.func == ist_pkg::FUNC_DELETE) ? ist_pkg::ST_MOVE_RD
                                                           : ist_pkg::ST_EXEC;
         end
         ist_pkg::ST_MOVE_RD: begin
            cmd.rd_last = 1'b1;
            state_in    = ist_pkg::ST_EXEC;
         end
         ist_pkg::ST_READ: begin
            cmd.rd_idx = 1'b1;
            state_in   = ist_pkg::ST_EXEC;
         end
         ist_pkg::ST_EXEC: begin
            // hold until the result register can take the transaction
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = ist_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ist_pkg::ST_IDLE;
         end
      endcase
   end

   // checks
   `IST_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd))
   `IST_ASSERT_NEXT(a_load_dispatch, cmd.load, state_ff == ist_pkg::ST_DISPATCH)
   `IST_ASSERT_SAME(a_scan_end_order, state_ff == ist_pkg::ST_SCAN_END,
                    $past(state_ff) == ist_pkg::ST_SCAN)

endmodule

/* hdl/ist_dpath.sv */
// datapath for the integer set table: request capture, entry table,
// compare scan, update logic and result register
// depends on ist_pkg and integer_set_table_top_assert.svh
`include "integer_set_table_top_assert.svh"

module ist_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  ist_pkg::cmd_type                  cmd,
   output ist_pkg::sts_type                  sts,
   input  logic [ist_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [ist_pkg::FUNC_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ist_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [ist_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int unsigned CAPACITY = ist_pkg::CAPACITY;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned XW = (CW > 8) ? CW : 8;

   // request capture
   ist_pkg::func_type   func_ff, func_in;
   logic signed [31:0]  value_ff, value_in;
   logic signed [31:0]  new_value_ff, new_value_in;
   logic [7:0]          index_ff, index_in;

   // table state
   logic [31:0]         entry_mem [CAPACITY];
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       count_m1;
   logic                full;
   logic                idx_ok;

   // scan pipeline
   logic [AW-1:0]       scan_addr_ff, scan_addr_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]       cmp_addr_ff, cmp_addr_in;
   logic [31:0]         rd_data_ff;
   logic                hit_v_ff, hit_v_in;
   logic                hit_nv_ff, hit_nv_in;
   logic [AW-1:0]       pos_ff, pos_in;

   // table ports
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [31:0]         wr_data;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   ist_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [31:0]            rsp_read_ff, rsp_read_in;
   logic [4:0]             rsp_count_ff, rsp_count_in;
   logic [CW+4:0]          count_wide;

   assign count_m1 = count_ff - 1'b1;
   assign full     = (count_ff == CW'(CAPACITY));
   assign idx_ok   = (XW'(index_ff) < XW'(count_ff));

   // status to controller
   assign sts.func       = func_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.scan_last  = (scan_addr_ff == count_m1[AW-1:0]);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   // request capture on load
   always_comb begin
      func_in      = func_ff;
      value_in     = value_ff;
      new_value_in = new_value_ff;
      index_in     = index_ff;
      if (cmd.load) begin
         func_in      = ist_pkg::func_type'(req_tuser);
         value_in     = req_tdata[31:0];
         new_value_in = req_tdata[63:32];
         index_in     = req_tdata[71:64];
      end
   end

   // scan address, compare pipeline and hit tracking
   always_comb begin
      scan_addr_in = scan_addr_ff;
      cmp_vld_in   = cmd.scan;
      cmp_addr_in  = scan_addr_ff;
      hit_v_in     = hit_v_ff;
      hit_nv_in    = hit_nv_ff;
      pos_in       = pos_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
         hit_v_in     = 1'b0;
         hit_nv_in    = 1'b0;
         pos_in       = '0;
      end else begin
         if (cmd.scan) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         if (cmp_vld_ff) begin
            // keep the first matching position only
            if ((rd_data_ff == value_ff) && !hit_v_ff) begin
               hit_v_in = 1'b1;
               pos_in   = cmp_addr_ff;
            end
            if (rd_data_ff == new_value_ff) begin
               hit_nv_in = 1'b1;
            end
         end
      end
   end

   // table read address select
   always_comb begin
      rd_en   = cmd.scan || cmd.rd_last || cmd.rd_idx;
      rd_addr = scan_addr_ff;
      if (cmd.rd_last) begin
         rd_addr = count_m1[AW-1:0];
      end else if (cmd.rd_idx) begin
         rd_addr = index_ff[AW-1:0];
      end
   end

   // operation update and result
   always_comb begin
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = new_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (cmd.exec) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ist_pkg::STAT_OK;
         rsp_found_in  = 1'b0;
         rsp_read_in   = '0;
         case (func_ff)
            ist_pkg::FUNC_INSERT: begin
               if (hit_v_ff) begin
                  rsp_status_in = ist_pkg::STAT_DUP;
               end else if (full) begin
                  rsp_status_in = ist_pkg::STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = value_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            ist_pkg::FUNC_DELETE: begin
               // last entry fills the hole
               if (!hit_v_ff) begin
                  rsp_status_in = ist_pkg::STAT_NOT_FOUND;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data_ff;
                  count_in = count_m1;
               end
            end
            ist_pkg::FUNC_SEARCH: begin
               rsp_found_in = hit_v_ff;
            end
            ist_pkg::FUNC_REPLACE: begin
               if (!hit_v_ff) begin
                  rsp_status_in = ist_pkg::STAT_NOT_FOUND;
               end else if (hit_nv_ff) begin
                  rsp_status_in = ist_pkg::STAT_DUP;
               end else begin
                  wr_en = 1'b1;
               end
            end
            ist_pkg::FUNC_CLEAR: begin
               count_in = '0;
            end
            ist_pkg::FUNC_READ: begin
               if (idx_ok) begin
                  rsp_read_in = rd_data_ff;
               end else begin
                  rsp_status_in = ist_pkg::STAT_RANGE;
               end
            end
            default: begin
               rsp_status_in = ist_pkg::STAT_OK;
            end
         endcase
      end
   end

   assign count_wide   = {5'b00000, count_in};
   assign rsp_count_in = cmd.exec ? count_wide[4:0] : rsp_count_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      new_value_ff  <= new_value_in;
      index_ff      <= index_in;
      scan_addr_ff  <= scan_addr_in;
      cmp_addr_ff   <= cmp_addr_in;
      hit_v_ff      <= hit_v_in;
      hit_nv_ff     <= hit_nv_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // entry table, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // result channel: tdata = found, read_value, count, zero pad
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_read_ff, rsp_found_ff};
   assign rsp_tuser  = rsp_status_ff;

   // checks
   `IST_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY))
   `IST_ASSERT_SAME(a_scan_nonempty, cmd.scan, count_ff != '0)
   `IST_ASSERT_NEXT(a_exec_result, cmd.exec, rsp_valid_ff)

endmodule

/* hdl/integer_set_table_top.sv */
// top level of the integer set table: controller plus datapath
// depends on ist_pkg, ist_ctrl and ist_dpath
//
// Bounded set of up to ist_pkg::CAPACITY (16) signed 32-bit values in an
// unsorted table. Each request transaction (insert, delete, search, replace,
// clear, read by index) yields exactly one response transaction carrying
// status, found flag, read value and the entry count after the operation.
// Insert, delete, search and replace walk the table one entry per cycle
// through its single read port, so such a request occupies the block longer
// the more valid entries it holds (an empty table skips the walk); delete
// also fetches the last entry to fill the hole, and read by index fetches
// the entry it names. The response sits in an output register, so a new
// request is taken while a finished response still waits for rsp_tready.
// Table contents are not cleared by reset; only the count is.

module integer_set_table_top (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = value[31:0], new_value[63:32], index[71:64]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ist_pkg::REQ_DATA_W-1:0]    req_tdata,
   // request: tuser = func[2:0]
   input  logic [ist_pkg::FUNC_W-1:0]        req_tuser,
   // response: tdata = found[0], read_value[32:1], count[37:33], zero[39:38]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ist_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // response: tuser = status[2:0]
   output logic [ist_pkg::STATUS_W-1:0]      rsp_tuser
);

   ist_pkg::cmd_type cmd;
   ist_pkg::sts_type sts;

   // sequencer
   ist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // table and compare datapath
   ist_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* sim/tb_top.sv */
// self-checking testbench for integer_set_table_top: streams set operations in,
// predicts each response with its own set model; depends on ist_pkg and the rtl
module tb_top;

   // operation codes the block ignores
   localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_B = 3'd7;
   localparam int unsigned RANDOM_OPS   = 1900;
   localparam int unsigned MAX_GAP      = 8;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned HOLD_SPACING = 700;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] value;
      logic [31:0] new_value;
      logic [7:0]  index;
   } set_op_type;

   typedef struct packed {
      ist_pkg::status_type          status;
      logic                         found;
      logic [31:0]                  read_value;
      logic [ist_pkg::COUNT_W-1:0]  count;
   } set_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ist_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ist_pkg::FUNC_W-1:0]     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ist_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [ist_pkg::STATUS_W-1:0]   rsp_tuser;

   // operations waiting to be offered, and responses the set model predicts
   set_op_type     op_queue[$];
   set_result_type results_due[$];

   // set model state
   logic [31:0] table_model [ist_pkg::CAPACITY];
   int unsigned count_model = 0;

   // handshake flags sampled at the rising edge
   bit          req_fire = 1'b0;
   bit          rsp_fire = 1'b0;
   int unsigned ops_accepted = 0;
   int unsigned quiet_cycles = 0;
   int unsigned fail_count = 0;

   // driver and receiver pacing
   set_op_type  next_op;
   int unsigned req_gap = 0;
   bit          req_quiet = 1'b0;
   int unsigned rsp_wait = 0;
   bit          rsp_quiet = 1'b0;
   int unsigned hold_left = 0;
   int unsigned next_hold_at = 300;
   logic        rsp_hold = 1'b0;

   integer_set_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // value[31:0], new_value[63:32], index[71:64]
      .req_tuser (req_tuser),   // func[2:0]
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),   // found[0], read_value[32:1], count[37:33]
      .rsp_tuser (rsp_tuser)    // status[2:0]
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // position of a held value in the model, or the count when absent
   function automatic int unsigned slot_of(logic [31:0] v);
      for (int unsigned i = 0; i < count_model; i++) begin
         if (table_model[i] == v) return i;
      end
      return count_model;
   endfunction

   // run one operation on the model and return the response it yields
   function automatic set_result_type apply_set_op(set_op_type op);
      set_result_type r;
      int unsigned pos;
      r.status     = ist_pkg::STAT_OK;
      r.found      = 1'b0;
      r.read_value = '0;
      case (op.func)
         ist_pkg::FUNC_INSERT: begin
            if (slot_of(op.value) < count_model) r.status = ist_pkg::STAT_DUP;
            else if (count_model >= ist_pkg::CAPACITY) r.status = ist_pkg::STAT_FULL;
            else begin
               table_model[count_model] = op.value;
               count_model++;
            end
         end
         ist_pkg::FUNC_DELETE: begin
            pos = slot_of(op.value);
            if (pos >= count_model) r.status = ist_pkg::STAT_NOT_FOUND;
            else begin
               // last valid entry fills the hole
               count_model--;
               table_model[pos] = table_model[count_model];
            end
         end
         ist_pkg::FUNC_SEARCH: begin
            r.found = (slot_of(op.value) < count_model);
         end
         ist_pkg::FUNC_REPLACE: begin
            pos = slot_of(op.value);
            if (pos >= count_model) r.status = ist_pkg::STAT_NOT_FOUND;
            else if (slot_of(op.new_value) < count_model) r.status = ist_pkg::STAT_DUP;
            else table_model[pos] = op.new_value;
         end
         ist_pkg::FUNC_CLEAR: begin
            count_model = 0;
         end
         ist_pkg::FUNC_READ: begin
            if (op.index < count_model) r.read_value = table_model[op.index];
            else r.status = ist_pkg::STAT_RANGE;
         end
         default: ;
      endcase
      r.count = ist_pkg::COUNT_W'(count_model);
      return r;
   endfunction

   task automatic queue_op(logic [2:0] func, logic [31:0] value, logic [31:0] new_value,
                           logic [7:0] index);
      set_op_type op;
      op.func      = func;
      op.value     = value;
      op.new_value = new_value;
      op.index     = index;
      op_queue.push_back(op);
   endtask

   // candidate value: full-range random, small signed or an extreme
   function automatic logic [31:0] fresh_value();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         1: begin
            v = $urandom_range(0, 40);
            v = v - 32'd20;
         end
         2: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // stimulus and end of run
   initial begin
      logic [31:0] pool[$];
      logic [31:0] value;
      logic [31:0] new_value;
      logic [7:0]  index;
      logic [2:0]  func;
      int unsigned real_ops;
      int unsigned mode;
      int unsigned ins_pct;
      int unsigned del_pct;
      int unsigned roll;
      int unsigned total_ops;

      // directed: empty table cases
      queue_op(ist_pkg::FUNC_SEARCH,  32'd0, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_READ,    32'd0, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_DELETE,  32'd5, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_REPLACE, 32'd5, 32'd6, 8'd0);
      // extremes of the value range, then a duplicate
      queue_op(ist_pkg::FUNC_INSERT,  32'h8000_0000, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_INSERT,  32'h7fff_ffff, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_INSERT,  32'h0000_0000, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_INSERT,  32'hffff_ffff, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_INSERT,  32'h7fff_ffff, 32'd0, 8'd0);
      // search hit and miss
      queue_op(ist_pkg::FUNC_SEARCH,  32'h8000_0000, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_SEARCH,  32'd1, 32'd0, 8'd0);
      // reads in range, at the count and at the top index
      queue_op(ist_pkg::FUNC_READ,    32'd0, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_READ,    32'd0, 32'd0, 8'd3);
      queue_op(ist_pkg::FUNC_READ,    32'd0, 32'd0, 8'd4);
      queue_op(ist_pkg::FUNC_READ,    32'd0, 32'd0, 8'd255);
      // replace: equal value, new value held, old value absent, success
      queue_op(ist_pkg::FUNC_REPLACE, 32'd0, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_REPLACE, 32'd0, 32'h7fff_ffff, 8'd0);
      queue_op(ist_pkg::FUNC_REPLACE, 32'd12345, 32'd7, 8'd0);
      queue_op(ist_pkg::FUNC_REPLACE, 32'd0, 32'h5555_5555, 8'd0);
      // delete moves the last entry into the hole, then a miss
      queue_op(ist_pkg::FUNC_DELETE,  32'h8000_0000, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_DELETE,  32'h8000_0000, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_READ,    32'd0, 32'd0, 8'd0);
      // ignored codes, clear, search after clear
      queue_op(FUNC_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
      queue_op(FUNC_SPARE_B, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
      queue_op(ist_pkg::FUNC_CLEAR,   32'd0, 32'd0, 8'd0);
      queue_op(ist_pkg::FUNC_SEARCH,  32'h7fff_ffff, 32'd0, 8'd0);

      // random episodes over a small value pool so that hits, fills and
      // duplicates are common; mode picks fill, churn or drain
      real_ops = 0;
      while (real_ops < RANDOM_OPS) begin
         mode = $urandom_range(0, 2);
         ins_pct = (mode == 0) ? 60 : (mode == 1) ? 35 : 15;
         del_pct = (mode == 0) ? 10 : (mode == 1) ? 25 : 50;
         pool.delete();
         repeat ((mode == 0) ? $urandom_range(18, 28) : $urandom_range(4, 20))
            pool.push_back(fresh_value());
         repeat ($urandom_range(20, 80)) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
            else if (roll < 4) func = ist_pkg::FUNC_CLEAR;
            else if (roll < 4 + ins_pct) func = ist_pkg::FUNC_INSERT;
            else if (roll < 4 + ins_pct + del_pct) func = ist_pkg::FUNC_DELETE;
            else begin
               case ($urandom_range(0, 2))
                  0: func = ist_pkg::FUNC_SEARCH;
                  1: func = ist_pkg::FUNC_REPLACE;
                  default: func = ist_pkg::FUNC_READ;
               endcase
            end
            value = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool.size() - 1)]
                                                 : $urandom;
            new_value = ($urandom_range(0, 99) < 70) ? pool[$urandom_range(0, pool.size() - 1)]
                                                     : $urandom;
            index = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 17))
                                                 : 8'($urandom_range(0, 255));
            queue_op(func, value, new_value, index);
            if (func != FUNC_SPARE_A && func != FUNC_SPARE_B) real_ops++;
         end
      end
      total_ops = op_queue.size();

      // hold synchronous reset, then release it
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // wait for every response, then let the pipeline settle
      while (ops_accepted < total_ops || results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count += results_due.size();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // request driver: holds each transaction until taken, random gaps between
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (op_queue.size() > 0) begin
            next_op = op_queue.pop_front();
            req_tdata  <= {next_op.index, next_op.new_value, next_op.value};
            req_tuser  <= next_op.func;
            req_tvalid <= 1'b1;
            req_gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 63) == 0) req_quiet = !req_quiet;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the output register fills and input stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
      end else if (!reset && ops_accepted >= next_hold_at) begin
         hold_left = HOLD_CYCLES;
         next_hold_at += HOLD_SPACING;
      end
      rsp_hold <= (hold_left > 0);
   end

   // response receiver: random stall before each transaction
   always @(negedge clock) begin
      if (rsp_fire) begin
         rsp_wait = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 63) == 0) rsp_quiet = !rsp_quiet;
      end
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check responses, predict accepted requests, watchdog
   always @(posedge clock) begin
      set_op_type     taken;
      set_result_type want;
      set_result_type got;
      if (reset) begin
         req_fire = 1'b0;
         rsp_fire = 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         rsp_fire = rsp_tvalid && rsp_tready;

         if (rsp_fire) begin
            got.status     = ist_pkg::status_type'(rsp_tuser);
            got.found      = rsp_tdata[0];
            got.read_value = rsp_tdata[32:1];
            got.count      = rsp_tdata[37:33];
            if (results_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected response: status %0d found %0d value %h count %0d",
                           got.status, got.found, got.read_value, got.count);
            end else begin
               want = results_due.pop_front();
               if (got.status !== want.status || got.found !== want.found ||
                   got.read_value !== want.read_value || got.count !== want.count) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"response mismatch: expected status %0d found %0d value %h ",
                               "count %0d, got status %0d found %0d value %h count %0d"},
                              want.status, want.found, want.read_value, want.count,
                              got.status, got.found, got.read_value, got.count);
               end
            end
         end

         if (req_fire) begin
            taken.func      = req_tuser;
            taken.value     = req_tdata[31:0];
            taken.new_value = req_tdata[63:32];
            taken.index     = req_tdata[71:64];
            results_due.push_back(apply_set_op(taken));
            ops_accepted++;
         end

         if (req_fire || rsp_fire) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

endmodule
